// ===== rtl/core/nearest_neighbor_scale_address_gen_core_assert.svh =====
// Assertion macros for the nearest-neighbour scale address generator
`ifndef NEAREST_NEIGHBOR_SCALE_ADDRESS_GEN_CORE_ASSERT_SVH
`define NEAREST_NEIGHBOR_SCALE_ADDRESS_GEN_CORE_ASSERT_SVH

// same-cycle implication
`define NNSAG_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("nnsag: same-cycle check failed");

// next-cycle implication
`define NNSAG_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("nnsag: next-cycle check failed");

`endif

// ===== rtl/core/nnsag_pkg.sv =====
// Shared types and constants of the nearest-neighbour scale address generator
package nnsag_pkg;

    localparam int CNT_W         = 12;
    localparam int ORG_W         = 12;
    localparam int DIM_W         = 13;
    localparam int PROD_W        = CNT_W + DIM_W;
    localparam int REM_W         = DIM_W - 1;
    localparam int STEP_W        = $clog2(PROD_W);
    localparam int MAC_STEP_W    = $clog2(DIM_W);
    localparam int OUT_W         = 24;
    localparam int ADDR_BITS_DEF = 24;
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_DATA_W    = 16;

    localparam logic [DIM_W-1:0] DIM_MAX        = 13'd4096;
    localparam logic [DIM_W-1:0] SRC_STRIDE_RST = 13'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_ORIGIN_X = 4'd0,
        REG_SRC_ORIGIN_Y = 4'd1,
        REG_SRC_STRIDE   = 4'd2,
        REG_SRC_WIDTH    = 4'd3,
        REG_SRC_HEIGHT   = 4'd4,
        REG_DST_WIDTH    = 4'd5,
        REG_DST_HEIGHT   = 4'd6,
        REG_DST_STRIDE   = 4'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCALE,
        ST_SUM,
        ST_OUT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        SC_IDLE,
        SC_MUL,
        SC_DIV
    } scale_phase_t;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] num;
        logic [DIM_W-1:0] mul;
        logic [DIM_W-1:0] den;
    } scale_req_t;

    typedef struct packed {
        logic              start;
        logic [ORG_W-1:0]  org_x;
        logic [PROD_W-1:0] xs;
        logic [ORG_W-1:0]  org_y;
        logic [PROD_W-1:0] ys;
        logic [DIM_W-1:0]  stride;
    } mac_req_t;

endpackage

// ===== rtl/core/nearest_neighbor_scale_address_gen_core.sv =====
// Top level of the nearest-neighbour scale address generator.
// Each input passes through the scalers (13 multiply steps and 25 divide steps),
// then the address sum (13 steps), then the output register. A new input is
// accepted only once the serial scale and sum units have delivered the previous result.
// Reset: synchronous active-low aresetn clears counters, pointer and control, and
// returns the config registers to their defaults.
module nearest_neighbor_scale_address_gen_core
    import nnsag_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_restart,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [OUT_W-1:0]      m_src_addr,
    output logic [OUT_W-1:0]      m_dst_addr,
    output logic                  m_row_end,
    output logic                  m_frame_end,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ctrl_state_t state_reg, state_next;

    logic [ORG_W-1:0] src_origin_x_reg, src_origin_x_next;
    logic [ORG_W-1:0] src_origin_y_reg, src_origin_y_next;
    logic [DIM_W-1:0] src_stride_reg, src_stride_next;
    logic [DIM_W-1:0] src_width_reg, src_width_next;
    logic [DIM_W-1:0] src_height_reg, src_height_next;
    logic [DIM_W-1:0] dst_width_reg, dst_width_next;
    logic [DIM_W-1:0] dst_height_reg, dst_height_next;
    logic [DIM_W-1:0] dst_stride_reg, dst_stride_next;

    logic [CNT_W-1:0]     col_reg, col_next;
    logic [CNT_W-1:0]     row_reg, row_next;
    logic [ADDR_BITS-1:0] ptr_reg, ptr_next;

    logic [ADDR_BITS-1:0] item_dst_reg;
    logic                 item_rend_reg;
    logic                 item_fend_reg;

    logic                 m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]     m_src_addr_reg;
    logic [OUT_W-1:0]     m_dst_addr_reg;
    logic                 m_row_end_reg;
    logic                 m_frame_end_reg;

    logic                 s_fire;
    logic                 out_load;
    logic                 mac_start;
    logic [CNT_W-1:0]     col_cur;
    logic [CNT_W-1:0]     row_cur;
    logic [ADDR_BITS-1:0] ptr_cur;
    logic [DIM_W-1:0]     dw;
    logic [DIM_W-1:0]     dh;
    logic                 rend;
    logic                 fend;

    scale_req_t           x_req;
    scale_req_t           y_req;
    mac_req_t             m_req;
    logic                 x_done;
    logic                 y_done;
    logic [PROD_W-1:0]    xs;
    logic [PROD_W-1:0]    ys;
    logic                 mac_done;
    logic [ADDR_BITS-1:0] mac_addr;

    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_comb begin
        src_origin_x_next = src_origin_x_reg;
        src_origin_y_next = src_origin_y_reg;
        src_stride_next   = src_stride_reg;
        src_width_next    = src_width_reg;
        src_height_next   = src_height_reg;
        dst_width_next    = dst_width_reg;
        dst_height_next   = dst_height_reg;
        dst_stride_next   = dst_stride_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SRC_ORIGIN_X: src_origin_x_next = cfg_data[ORG_W-1:0];
                REG_SRC_ORIGIN_Y: src_origin_y_next = cfg_data[ORG_W-1:0];
                REG_SRC_STRIDE:   src_stride_next   = cfg_data[DIM_W-1:0];
                REG_SRC_WIDTH:    src_width_next    = cfg_data[DIM_W-1:0];
                REG_SRC_HEIGHT:   src_height_next   = cfg_data[DIM_W-1:0];
                REG_DST_WIDTH:    dst_width_next    = cfg_data[DIM_W-1:0];
                REG_DST_HEIGHT:   dst_height_next   = cfg_data[DIM_W-1:0];
                REG_DST_STRIDE:   dst_stride_next   = cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp destination size to 1..4096
    always_comb begin
        if (dst_width_reg == '0) begin
            dw = DIM_W'(1);
        end else if (dst_width_reg > DIM_MAX) begin
            dw = DIM_MAX;
        end else begin
            dw = dst_width_reg;
        end
        if (dst_height_reg == '0) begin
            dh = DIM_W'(1);
        end else if (dst_height_reg > DIM_MAX) begin
            dh = DIM_MAX;
        end else begin
            dh = dst_height_reg;
        end
    end

    assign col_cur = s_restart ? '0 : col_reg;
    assign row_cur = s_restart ? '0 : row_reg;
    assign ptr_cur = s_restart ? '0 : ptr_reg;
    assign rend    = ({1'b0, col_cur} >= (dw - DIM_W'(1)));
    assign fend    = rend && ({1'b0, row_cur} >= (dh - DIM_W'(1)));

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        ptr_next = ptr_reg;
        if (s_fire) begin
            if (fend) begin
                col_next = '0;
                row_next = '0;
                ptr_next = '0;
            end else if (rend) begin
                col_next = '0;
                row_next = row_cur + CNT_W'(1);
                ptr_next = ptr_cur + ADDR_BITS'(1) + ADDR_BITS'(dst_stride_reg)
                         - ADDR_BITS'(dw);
            end else begin
                col_next = col_cur + CNT_W'(1);
                row_next = row_cur;
                ptr_next = ptr_cur + ADDR_BITS'(1);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                if (x_done && y_done) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                if (mac_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        mac_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_ready   = 1'b1;
            ST_SCALE: mac_start = x_done && y_done;
            ST_SUM:   ;
            ST_OUT:   out_load  = !m_valid_reg || m_ready;
            default:  ;
        endcase
    end

    assign x_req = '{start: s_fire, num: col_cur, mul: src_width_reg, den: dw};
    assign y_req = '{start: s_fire, num: row_cur, mul: src_height_reg, den: dh};
    assign m_req = '{start: mac_start, org_x: src_origin_x_reg, xs: xs,
                     org_y: src_origin_y_reg, ys: ys, stride: src_stride_reg};

    nnsag_scale u_scale_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (x_req),
        .done    (x_done),
        .quo     (xs)
    );

    nnsag_scale u_scale_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (y_req),
        .done    (y_done),
        .quo     (ys)
    );

    nnsag_mac #(
        .ADDR_BITS (ADDR_BITS)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (m_req),
        .done    (mac_done),
        .addr    (mac_addr)
    );

    assign m_valid_next = out_load || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            m_valid_reg      <= 1'b0;
            col_reg          <= '0;
            row_reg          <= '0;
            ptr_reg          <= '0;
            src_origin_x_reg <= '0;
            src_origin_y_reg <= '0;
            src_stride_reg   <= SRC_STRIDE_RST;
            src_width_reg    <= DIM_W'(1);
            src_height_reg   <= DIM_W'(1);
            dst_width_reg    <= DIM_W'(1);
            dst_height_reg   <= DIM_W'(1);
            dst_stride_reg   <= DIM_W'(1);
        end else begin
            state_reg        <= state_next;
            m_valid_reg      <= m_valid_next;
            col_reg          <= col_next;
            row_reg          <= row_next;
            ptr_reg          <= ptr_next;
            src_origin_x_reg <= src_origin_x_next;
            src_origin_y_reg <= src_origin_y_next;
            src_stride_reg   <= src_stride_next;
            src_width_reg    <= src_width_next;
            src_height_reg   <= src_height_next;
            dst_width_reg    <= dst_width_next;
            dst_height_reg   <= dst_height_next;
            dst_stride_reg   <= dst_stride_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_dst_reg  <= ptr_cur;
            item_rend_reg <= rend;
            item_fend_reg <= fend;
        end
        if (out_load) begin
            m_src_addr_reg  <= OUT_W'(mac_addr);
            m_dst_addr_reg  <= OUT_W'(item_dst_reg);
            m_row_end_reg   <= item_rend_reg;
            m_frame_end_reg <= item_fend_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_src_addr  = m_src_addr_reg;
    assign m_dst_addr  = m_dst_addr_reg;
    assign m_row_end   = m_row_end_reg;
    assign m_frame_end = m_frame_end_reg;

endmodule

// ===== rtl/core/nnsag_scale.sv =====
// Bit-serial scaler: floor(num * mul / den) by shift-add multiply then restoring divide
module nnsag_scale
    import nnsag_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  scale_req_t        req,
    output logic              done,
    output logic [PROD_W-1:0] quo
);

    scale_phase_t      phase_reg, phase_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  a_reg, a_next;
    logic [DIM_W-1:0]  d_reg, d_next;
    logic [DIM_W-1:0]  hi_reg, hi_next;
    logic [DIM_W-1:0]  lo_reg, lo_next;
    logic [PROD_W-1:0] dvd_reg, dvd_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [DIM_W:0]    sum;
    logic [DIM_W-1:0]  trial;
    logic              ge;
    logic              mul_last;
    logic              div_last;

    assign mul_last = (cnt_reg == STEP_W'(DIM_W - 1));
    assign div_last = (cnt_reg == STEP_W'(PROD_W - 1));
    assign sum      = {1'b0, hi_reg} + (lo_reg[0] ? (DIM_W + 1)'(a_reg) : '0);
    assign trial    = {rem_reg, dvd_reg[PROD_W-1]};
    assign ge       = (trial >= d_reg);

    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            SC_IDLE: begin
                if (req.start) begin
                    phase_next = SC_MUL;
                end
            end
            SC_MUL: begin
                if (mul_last) begin
                    phase_next = SC_DIV;
                end
            end
            SC_DIV: begin
                if (div_last) begin
                    phase_next = SC_IDLE;
                end
            end
            default: phase_next = SC_IDLE;
        endcase
    end

    always_comb begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        a_next    = a_reg;
        d_next    = d_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        unique case (phase_reg)
            SC_IDLE: begin
                if (req.start) begin
                    a_next   = req.num;
                    d_next   = req.den;
                    hi_next  = '0;
                    lo_next  = req.mul;
                    cnt_next = '0;
                end
            end
            SC_MUL: begin
                hi_next  = sum[DIM_W:1];
                lo_next  = {sum[0], lo_reg[DIM_W-1:1]};
                cnt_next = cnt_reg + STEP_W'(1);
                if (mul_last) begin
                    dvd_next = {hi_next[CNT_W-1:0], lo_next};
                    rem_next = '0;
                    cnt_next = '0;
                end
            end
            SC_DIV: begin
                rem_next = ge ? REM_W'(trial - d_reg) : trial[REM_W-1:0];
                dvd_next = {dvd_reg[PROD_W-2:0], ge};
                cnt_next = cnt_reg + STEP_W'(1);
                if (div_last) begin
                    done_next = 1'b1;
                    cnt_next  = '0;
                end
            end
            default: cnt_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= SC_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg   <= a_next;
        d_reg   <= d_next;
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign quo  = dvd_reg;

endmodule

// ===== rtl/core/nnsag_mac.sv =====
// Bit-serial source address sum: org_x + xs + (org_y + ys) * stride, modulo the address width
module nnsag_mac
    import nnsag_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mac_req_t             req,
    output logic                 done,
    output logic [ADDR_BITS-1:0] addr
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [MAC_STEP_W-1:0] cnt_reg, cnt_next;
    logic [ADDR_BITS-1:0]  acc_reg, acc_next;
    logic [ADDR_BITS-1:0]  m_reg, m_next;
    logic [DIM_W-1:0]      s_reg, s_next;
    logic                  last;

    assign last = (cnt_reg == MAC_STEP_W'(DIM_W - 1));

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        m_next    = m_reg;
        s_next    = s_reg;
        if (busy_reg) begin
            if (s_reg[0]) begin
                acc_next = acc_reg + m_reg;
            end
            m_next   = {m_reg[ADDR_BITS-2:0], 1'b0};
            s_next   = {1'b0, s_reg[DIM_W-1:1]};
            cnt_next = cnt_reg + MAC_STEP_W'(1);
            if (last) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                cnt_next  = '0;
            end
        end else if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = ADDR_BITS'(req.org_x) + ADDR_BITS'(req.xs);
            m_next    = ADDR_BITS'(req.org_y) + ADDR_BITS'(req.ys);
            s_next    = req.stride;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        m_reg   <= m_next;
        s_reg   <= s_next;
    end

    assign done = done_reg;
    assign addr = acc_reg;

endmodule

// ===== rtl/core/nnsag_checker.sv =====
// Port-level checks of the nearest-neighbour scale address generator, bound to the top level
`include "nearest_neighbor_scale_address_gen_core_assert.svh"

module nnsag_checker
    import nnsag_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic [OUT_W-1:0] m_src_addr,
    input logic [OUT_W-1:0] m_dst_addr,
    input logic             m_row_end,
    input logic             m_frame_end
);

    `NNSAG_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_src_addr) && $stable(m_dst_addr) && $stable(m_row_end) && $stable(m_frame_end))
    `NNSAG_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `NNSAG_ASSERT_IMP(a_frame_on_row_end, aclk, aresetn, m_valid && m_frame_end, m_row_end)

endmodule

bind nearest_neighbor_scale_address_gen_core nnsag_checker u_nnsag_checker (.*);
